// ===== rtl/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

  // Field widths of one input beat and one result beat.
  localparam int KindW   = 3;
  localparam int PosW    = 8;
  localparam int ValW    = 32;
  localparam int StatusW = 3;

  // Operation codes carried in the kind field.
  localparam logic [KindW-1:0] KIND_CLEAR  = 3'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 3'd1;
  localparam logic [KindW-1:0] KIND_DELETE = 3'd2;
  localparam logic [KindW-1:0] KIND_SEARCH = 3'd3;
  localparam logic [KindW-1:0] KIND_READ   = 3'd4;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Start value of the walking address.
  typedef enum logic [1:0] {
    AI_ZERO,
    AI_POS,
    AI_POS_M1,
    AI_CNT_M1
  } ainit_e;

  // Which data fills the result fields.
  typedef enum logic [1:0] {
    RS_NONE,
    RS_FOUND,
    RS_READ
  } rsel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ld;
    logic    ainit_en;
    ainit_e  ainit;
    logic    inc;
    logic    dec;
    logic    rd;
    logic    wr_val;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_ld;
    status_e res_st;
    rsel_e   res_sel;
    logic    out_ld;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             full;
    logic             empty;
    logic             ins_ok;
    logic             pos_ok;
    logic             ins_tail;
    logic             del_tail;
    logic             at_pos_m1;
    logic             at_cnt_m1;
    logic             hit;
  } sts_t;

endpackage

// ===== rtl/pal_if.sv =====
`timescale 1ns / 1ps

// Request channel: one operation per beat.
interface pal_in_if;
  logic                             valid;
  logic                             ready;
  logic [pal_pkg::KindW-1:0]        kind;
  logic [pal_pkg::PosW-1:0]         position;
  logic signed [pal_pkg::ValW-1:0]  value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

// Response channel: one result per beat.
interface pal_out_if;
  logic                             valid;
  logic                             ready;
  logic [pal_pkg::StatusW-1:0]      status;
  logic [pal_pkg::PosW-1:0]         found_position;
  logic signed [pal_pkg::ValW-1:0]  read_value;
  logic [pal_pkg::PosW-1:0]         count;

  modport source (output valid, status, found_position, read_value, count, input ready);
  modport sink   (input valid, status, found_position, read_value, count, output ready);
endinterface

// ===== rtl/pal_ram.sv =====
`timescale 1ns / 1ps

module pal_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pal_dp.sv =====
`timescale 1ns / 1ps

module pal_dp #(
  parameter int CAPACITY = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pal_pkg::KindW-1:0]    in_kind_i,
  input  logic [pal_pkg::PosW-1:0]     in_pos_i,
  input  logic [pal_pkg::ValW-1:0]     in_val_i,
  input  pal_pkg::cmd_t                cmd_i,
  output pal_pkg::sts_t                sts_o,
  output logic [pal_pkg::StatusW-1:0]  out_status_o,
  output logic [pal_pkg::PosW-1:0]     out_fpos_o,
  output logic [pal_pkg::ValW-1:0]     out_rval_o,
  output logic [pal_pkg::PosW-1:0]     out_count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > pal_pkg::PosW) ? CW : pal_pkg::PosW) + 1;
  localparam logic [PW-1:0] CapP = PW'(CAPACITY);

  logic [pal_pkg::KindW-1:0]   kind_q;
  logic [pal_pkg::PosW-1:0]    pos_q;
  logic [pal_pkg::ValW-1:0]    val_q;
  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               addr_q, addr_d;
  logic [AW-1:0]               prev_q;
  logic                        pend_q;
  logic [pal_pkg::StatusW-1:0] res_status_q;
  logic [pal_pkg::PosW-1:0]    res_fpos_q;
  logic [pal_pkg::ValW-1:0]    res_rval_q;
  logic [pal_pkg::StatusW-1:0] out_status_q;
  logic [pal_pkg::PosW-1:0]    out_fpos_q;
  logic [pal_pkg::ValW-1:0]    out_rval_q;
  logic [pal_pkg::PosW-1:0]    out_count_q;

  logic [PW-1:0]               pos_w, cnt_w, pos_m1, cnt_m1, cnt_p1, addr_w, fpos_w;
  logic [pal_pkg::ValW-1:0]    rdata;
  logic                        mv_wr, we;
  logic [AW-1:0]               waddr;
  logic [pal_pkg::ValW-1:0]    wdata;

  // Widened copies for position and count arithmetic.
  assign pos_w  = PW'(pos_q);
  assign cnt_w  = PW'(count_q);
  assign pos_m1 = pos_w - PW'(1);
  assign cnt_m1 = cnt_w - PW'(1);
  assign cnt_p1 = cnt_w + PW'(1);
  assign addr_w = PW'(addr_q);
  assign fpos_w = PW'(prev_q) + PW'(1);

  // Checks on the latched operation against the current count.
  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.full      = (cnt_w >= CapP);
    sts_o.empty     = (count_q == '0);
    sts_o.ins_ok    = (pos_w != '0) && (pos_w <= cnt_p1);
    sts_o.pos_ok    = (pos_w != '0) && (pos_w <= cnt_w);
    sts_o.ins_tail  = (pos_w == cnt_p1);
    sts_o.del_tail  = (pos_w == cnt_w);
    sts_o.at_pos_m1 = (addr_w == pos_m1);
    sts_o.at_cnt_m1 = (addr_w == cnt_m1);
    sts_o.hit       = pend_q && (rdata == val_q);
  end

  // Walking address: loaded at the start of a pass, then stepped once per cycle.
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.ainit_en) begin
      case (cmd_i.ainit)
        pal_pkg::AI_ZERO:   addr_d = '0;
        pal_pkg::AI_POS:    addr_d = pos_w[AW-1:0];
        pal_pkg::AI_POS_M1: addr_d = pos_m1[AW-1:0];
        pal_pkg::AI_CNT_M1: addr_d = cnt_m1[AW-1:0];
        default:            addr_d = '0;
      endcase
    end else if (cmd_i.inc) begin
      addr_d = addr_q + AW'(1);
    end else if (cmd_i.dec) begin
      addr_d = addr_q - AW'(1);
    end
  end

  // Entry count update.
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // A read issued during a shift pass is written back one place up or down
  // in the following cycle.
  assign mv_wr = pend_q && ((kind_q == pal_pkg::KIND_INSERT) ||
                            (kind_q == pal_pkg::KIND_DELETE));
  assign we    = mv_wr || cmd_i.wr_val;
  assign wdata = cmd_i.wr_val ? val_q : rdata;

  always_comb begin
    if (cmd_i.wr_val) begin
      waddr = pos_m1[AW-1:0];
    end else if (kind_q == pal_pkg::KIND_INSERT) begin
      waddr = prev_q + AW'(1);
    end else begin
      waddr = prev_q - AW'(1);
    end
  end

  pal_ram #(
    .Width (pal_pkg::ValW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= cmd_i.rd;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      kind_q <= in_kind_i;
      pos_q  <= in_pos_i;
      val_q  <= in_val_i;
    end
    addr_q <= addr_d;
    if (cmd_i.rd) begin
      prev_q <= addr_q;
    end
    if (cmd_i.res_ld) begin
      res_status_q <= cmd_i.res_st;
      res_fpos_q   <= (cmd_i.res_sel == pal_pkg::RS_FOUND) ? fpos_w[pal_pkg::PosW-1:0] : '0;
      res_rval_q   <= (cmd_i.res_sel == pal_pkg::RS_READ) ? rdata : '0;
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_status_q;
      out_fpos_q   <= res_fpos_q;
      out_rval_q   <= res_rval_q;
      out_count_q  <= cnt_w[pal_pkg::PosW-1:0];
    end
  end

  assign out_status_o = out_status_q;
  assign out_fpos_o   = out_fpos_q;
  assign out_rval_o   = out_rval_q;
  assign out_count_o  = out_count_q;

endmodule

// ===== rtl/pal_ctrl.sv =====
`timescale 1ns / 1ps

module pal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pal_pkg::sts_t sts_i,
  output pal_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP,
    S_UP_END,
    S_PUT,
    S_DN,
    S_DN_END,
    S_SCAN,
    S_SCAN_END,
    S_FETCH,
    S_FETCH_END,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  // Finish an operation with a given status and result source.
  function automatic pal_pkg::cmd_t finish(pal_pkg::cmd_t c, pal_pkg::status_e st,
                                           pal_pkg::rsel_e sel);
    pal_pkg::cmd_t r;
    r         = c;
    r.res_ld  = 1'b1;
    r.res_st  = st;
    r.res_sel = sel;
    return r;
  endfunction

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld = 1'b1;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_RESP;
        unique case (sts_i.kind)
          pal_pkg::KIND_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o = finish(cmd_o, pal_pkg::ST_OK, pal_pkg::RS_NONE);
          end
          pal_pkg::KIND_INSERT: begin
            if (sts_i.full) begin
              cmd_o = finish(cmd_o, pal_pkg::ST_FULL, pal_pkg::RS_NONE);
            end else if (!sts_i.ins_ok) begin
              cmd_o = finish(cmd_o, pal_pkg::ST_BADPOS, pal_pkg::RS_NONE);
            end else if (sts_i.ins_tail) begin
              state_d = S_PUT;
            end else begin
              cmd_o.ainit_en = 1'b1;
              cmd_o.ainit    = pal_pkg::AI_CNT_M1;
              state_d        = S_UP;
            end
          end
          pal_pkg::KIND_DELETE: begin
            if (sts_i.empty) begin
              cmd_o = finish(cmd_o, pal_pkg::ST_EMPTY, pal_pkg::RS_NONE);
            end else if (!sts_i.pos_ok) begin
              cmd_o = finish(cmd_o, pal_pkg::ST_BADPOS, pal_pkg::RS_NONE);
            end else if (sts_i.del_tail) begin
              cmd_o.cnt_dec = 1'b1;
              cmd_o = finish(cmd_o, pal_pkg::ST_OK, pal_pkg::RS_NONE);
            end else begin
              cmd_o.ainit_en = 1'b1;
              cmd_o.ainit    = pal_pkg::AI_POS;
              state_d        = S_DN;
            end
          end
          pal_pkg::KIND_SEARCH: begin
            if (sts_i.empty) begin
              cmd_o = finish(cmd_o, pal_pkg::ST_EMPTY, pal_pkg::RS_NONE);
            end else begin
              cmd_o.ainit_en = 1'b1;
              cmd_o.ainit    = pal_pkg::AI_ZERO;
              state_d        = S_SCAN;
            end
          end
          pal_pkg::KIND_READ: begin
            if (sts_i.empty) begin
              cmd_o = finish(cmd_o, pal_pkg::ST_EMPTY, pal_pkg::RS_NONE);
            end else if (!sts_i.pos_ok) begin
              cmd_o = finish(cmd_o, pal_pkg::ST_BADPOS, pal_pkg::RS_NONE);
            end else begin
              cmd_o.ainit_en = 1'b1;
              cmd_o.ainit    = pal_pkg::AI_POS_M1;
              state_d        = S_FETCH;
            end
          end
          default: begin
            cmd_o = finish(cmd_o, pal_pkg::ST_BADPOS, pal_pkg::RS_NONE);
          end
        endcase
      end
      // Walk down from the last entry, moving each one up a place.
      S_UP: begin
        cmd_o.rd = 1'b1;
        if (sts_i.at_pos_m1) begin
          state_d = S_UP_END;
        end else begin
          cmd_o.dec = 1'b1;
        end
      end
      S_UP_END: begin
        state_d = S_PUT;
      end
      S_PUT: begin
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        cmd_o = finish(cmd_o, pal_pkg::ST_OK, pal_pkg::RS_NONE);
        state_d = S_RESP;
      end
      // Walk up from the entry after the hole, moving each one down a place.
      S_DN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.at_cnt_m1) begin
          state_d = S_DN_END;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      S_DN_END: begin
        cmd_o.cnt_dec = 1'b1;
        cmd_o = finish(cmd_o, pal_pkg::ST_OK, pal_pkg::RS_NONE);
        state_d = S_RESP;
      end
      // Read one entry per cycle and compare the previous read against the key.
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.hit) begin
          cmd_o = finish(cmd_o, pal_pkg::ST_OK, pal_pkg::RS_FOUND);
          state_d = S_RESP;
        end else if (sts_i.at_cnt_m1) begin
          state_d = S_SCAN_END;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      S_SCAN_END: begin
        if (sts_i.hit) begin
          cmd_o = finish(cmd_o, pal_pkg::ST_OK, pal_pkg::RS_FOUND);
        end else begin
          cmd_o = finish(cmd_o, pal_pkg::ST_NOTFOUND, pal_pkg::RS_NONE);
        end
        state_d = S_RESP;
      end
      S_FETCH: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FETCH_END;
      end
      S_FETCH_END: begin
        cmd_o = finish(cmd_o, pal_pkg::ST_OK, pal_pkg::RS_READ);
        state_d = S_RESP;
      end
      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat is held until taken.
  always_comb begin
    if (cmd_o.out_ld) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/positional_array_list.sv =====
`timescale 1ns / 1ps
// One request is in flight at a time; the next is taken the cycle after the result
// is loaded. Clear, any error, read, and insert or delete at the tail need no walk;
// insert and delete elsewhere and search walk over the entry RAM, one entry per
// cycle, and the walk makes these the longest operations. Reset empties the list;
// entries are undefined until written.

module positional_array_list #(
  parameter int CAPACITY = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pal_in_if.sink            in_i,
  pal_out_if.source         out_o
);

  pal_pkg::cmd_t            cmd;
  pal_pkg::sts_t            sts;
  logic [pal_pkg::ValW-1:0] rval;

  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_kind_i    (in_i.kind),
    .in_pos_i     (in_i.position),
    .in_val_i     (in_i.value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_status_o (out_o.status),
    .out_fpos_o   (out_o.found_position),
    .out_rval_o   (rval),
    .out_count_o  (out_o.count)
  );

  assign out_o.read_value = rval;

  // A request beat is never followed directly by another one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while another is in flight");

  // A value is never placed into a full list.
  a_no_put_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_val |-> !sts.full)
    else $error("insert write with list full");

  // A waiting result is never overwritten.
  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten before it was taken");

endmodule

// ===== tb/positional_array_list_tb.sv =====
`timescale 1ns / 1ps

module positional_array_list_tb;

  localparam int Capacity    = 128;
  localparam int ClkPeriod   = 4;
  localparam int ResetCycles = 12;
  localparam int CycleLimit  = 2_000_000;
  // Longest walk of the block plus margin, for stray results at the end.
  localparam int DrainCycles = Capacity + 16;
  localparam int MaxPrinted  = 40;
  localparam int RandomItems = 1200;

  // One result beat as the list should report it.
  typedef struct {
    pal_pkg::status_e                status;
    logic [pal_pkg::PosW-1:0]        found_pos;
    logic signed [pal_pkg::ValW-1:0] read_val;
    logic [pal_pkg::PosW-1:0]        count;
  } list_result_t;

  // Receiver back-pressure patterns.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC,
    RDY_SPARSE
  } stall_mode_e;

  logic        clk;
  logic        rst_n;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 1;

  // Shadow copy of the list contents and the results still to arrive.
  logic signed [pal_pkg::ValW-1:0] list_model[$];
  list_result_t                    pending_results[$];

  pal_in_if  req_if ();
  pal_out_if rsp_if ();

  positional_array_list #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Cycle counter with a hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("positional_array_list_tb: FAIL");
      $finish;
    end
  end

  // Applies one operation to the shadow list and returns the result it must give.
  function automatic list_result_t apply_op(logic [pal_pkg::KindW-1:0] kind,
                                            logic [pal_pkg::PosW-1:0] pos,
                                            logic signed [pal_pkg::ValW-1:0] val);
    list_result_t res;
    int           n;
    res.status    = pal_pkg::ST_OK;
    res.found_pos = '0;
    res.read_val  = '0;
    n = list_model.size();
    case (kind)
      pal_pkg::KIND_CLEAR: begin
        list_model.delete();
      end
      pal_pkg::KIND_INSERT: begin
        if (n >= Capacity) res.status = pal_pkg::ST_FULL;
        else if (pos < 1 || pos > n + 1) res.status = pal_pkg::ST_BADPOS;
        else list_model.insert(pos - 1, val);
      end
      pal_pkg::KIND_DELETE: begin
        if (n == 0) res.status = pal_pkg::ST_EMPTY;
        else if (pos < 1 || pos > n) res.status = pal_pkg::ST_BADPOS;
        else list_model.delete(pos - 1);
      end
      pal_pkg::KIND_SEARCH: begin
        if (n == 0) begin
          res.status = pal_pkg::ST_EMPTY;
        end else begin
          res.status = pal_pkg::ST_NOTFOUND;
          for (int idx = 0; idx < n; idx++) begin
            if (list_model[idx] == val) begin
              res.status    = pal_pkg::ST_OK;
              res.found_pos = pal_pkg::PosW'(idx + 1);
              break;
            end
          end
        end
      end
      pal_pkg::KIND_READ: begin
        if (n == 0) res.status = pal_pkg::ST_EMPTY;
        else if (pos < 1 || pos > n) res.status = pal_pkg::ST_BADPOS;
        else res.read_val = list_model[pos - 1];
      end
      default: begin
        res.status = pal_pkg::ST_BADPOS;
      end
    endcase
    res.count = pal_pkg::PosW'(list_model.size());
    return res;
  endfunction

  // Either a full-width random value or a small one, so that duplicates occur.
  function automatic logic signed [pal_pkg::ValW-1:0] rand_value();
    if ($urandom_range(0, 1) == 1) return $urandom;
    return int'($urandom_range(0, 31)) - 16;
  endfunction

  // Mostly a legal position 1..limit, sometimes zero or a position past the end.
  function automatic logic [pal_pkg::PosW-1:0] pick_position(int unsigned limit);
    if (limit == 0 || $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 2) == 0 || limit >= 255) return '0;
      return pal_pkg::PosW'($urandom_range(limit + 1, 255));
    end
    return pal_pkg::PosW'($urandom_range(1, limit));
  endfunction

  task automatic report_mismatch(string what, logic [pal_pkg::ValW-1:0] got,
                                 logic [pal_pkg::ValW-1:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Holds valid low with junk on the payload; n sets how long.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid    = 1'b0;
      req_if.kind     = pal_pkg::KindW'($urandom);
      req_if.position = pal_pkg::PosW'($urandom);
      req_if.value    = $urandom;
    end
  endtask

  // Sends one request beat, records its result, then paces the next burst.
  task automatic send_op(logic [pal_pkg::KindW-1:0] kind, logic [pal_pkg::PosW-1:0] pos,
                         logic signed [pal_pkg::ValW-1:0] val);
    @(negedge clk);
    req_if.valid    = 1'b1;
    req_if.kind     = kind;
    req_if.position = pos;
    req_if.value    = val;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(apply_op(kind, pos, val));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 10));
      // Some bursts are long, giving stretches without sender gaps.
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 12);
    end
  endtask

  // Drops valid so the last beat is not taken twice, then waits for every result.
  task automatic wait_for_results();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty-list errors, position limits, both value extremes, duplicates, unused kinds.
  task automatic test_directed();
    int k;
    send_op(pal_pkg::KIND_SEARCH, 8'd0, 32'sd5);
    send_op(pal_pkg::KIND_DELETE, 8'd1, '0);
    send_op(pal_pkg::KIND_READ, 8'd1, '0);
    send_op(pal_pkg::KIND_INSERT, 8'd0, 32'sd1);
    send_op(pal_pkg::KIND_INSERT, 8'd2, 32'sd1);
    send_op(pal_pkg::KIND_INSERT, 8'd1, 32'sh8000_0000);
    send_op(pal_pkg::KIND_INSERT, 8'd2, 32'sh7fff_ffff);
    send_op(pal_pkg::KIND_INSERT, 8'd1, -32'sd1);
    send_op(pal_pkg::KIND_INSERT, 8'd4, 32'sh7fff_ffff);
    send_op(pal_pkg::KIND_SEARCH, 8'd0, 32'sh7fff_ffff);
    send_op(pal_pkg::KIND_SEARCH, 8'd0, 32'sd0);
    send_op(pal_pkg::KIND_READ, 8'd1, '0);
    send_op(pal_pkg::KIND_READ, 8'd4, '0);
    send_op(pal_pkg::KIND_READ, 8'd5, '0);
    send_op(pal_pkg::KIND_READ, 8'd255, '0);
    send_op(pal_pkg::KIND_DELETE, 8'd0, '0);
    send_op(pal_pkg::KIND_DELETE, 8'd255, '0);
    send_op(pal_pkg::KIND_DELETE, 8'd4, '0);
    send_op(pal_pkg::KIND_DELETE, 8'd1, '0);
    for (k = pal_pkg::KIND_READ + 1; k < 2 ** pal_pkg::KindW; k++) begin
      send_op(k[pal_pkg::KindW-1:0], 8'd255, -32'sd1);
    end
    send_op(pal_pkg::KIND_CLEAR, 8'd7, 32'sd9);
    send_op(pal_pkg::KIND_SEARCH, 8'd0, 32'sd0);
    send_op(pal_pkg::KIND_READ, 8'd1, '0);
  endtask

  // Fills the list to capacity, probes the full case, then empties it from the front.
  task automatic test_full_list();
    send_op(pal_pkg::KIND_CLEAR, '0, '0);
    repeat (Capacity) begin
      send_op(pal_pkg::KIND_INSERT,
              pal_pkg::PosW'($urandom_range(1, list_model.size() + 1)), rand_value());
    end
    send_op(pal_pkg::KIND_INSERT, Capacity[pal_pkg::PosW-1:0], rand_value());
    send_op(pal_pkg::KIND_INSERT, 8'd0, rand_value());
    send_op(pal_pkg::KIND_INSERT, 8'd255, rand_value());
    send_op(pal_pkg::KIND_SEARCH, '0, list_model[Capacity-1]);
    send_op(pal_pkg::KIND_SEARCH, '0, $urandom);
    send_op(pal_pkg::KIND_READ, Capacity[pal_pkg::PosW-1:0], '0);
    send_op(pal_pkg::KIND_READ, Capacity[pal_pkg::PosW-1:0] + 8'd1, '0);
    send_op(pal_pkg::KIND_DELETE, Capacity[pal_pkg::PosW-1:0], '0);
    send_op(pal_pkg::KIND_INSERT, Capacity[pal_pkg::PosW-1:0], $urandom);
    while (list_model.size() != 0) send_op(pal_pkg::KIND_DELETE, 8'd1, '0);
    send_op(pal_pkg::KIND_DELETE, 8'd1, '0);
  endtask

  // Random mix that drifts the list up and down between empty and full.
  task automatic test_random(int unsigned n_items);
    int unsigned                     n;
    int unsigned                     pick;
    int unsigned                     ins_w;
    logic                            grow;
    logic [pal_pkg::KindW-1:0]       kind;
    logic [pal_pkg::PosW-1:0]        pos;
    logic signed [pal_pkg::ValW-1:0] val;
    grow = 1'b1;
    repeat (n_items) begin
      n = list_model.size();
      if (n >= Capacity) grow = 1'b0;
      else if (n == 0) grow = 1'b1;
      else if ($urandom_range(0, 399) == 0) grow = !grow;
      ins_w = grow ? 45 : 12;
      pick  = $urandom_range(0, 99);
      pos   = pal_pkg::PosW'($urandom);
      val   = rand_value();
      if (pick < ins_w) begin
        kind = pal_pkg::KIND_INSERT;
        pos  = pick_position(n + 1);
      end else if (pick < 57) begin
        kind = pal_pkg::KIND_DELETE;
        pos  = pick_position(n);
      end else if (pick < 79) begin
        kind = pal_pkg::KIND_SEARCH;
        if (n != 0 && $urandom_range(0, 2) != 0) val = list_model[$urandom_range(0, n - 1)];
      end else if (pick < 97) begin
        kind = pal_pkg::KIND_READ;
        pos  = pick_position(n);
      end else if (pick < 99) begin
        kind = pal_pkg::KindW'($urandom_range(pal_pkg::KIND_READ + 1,
                                              2 ** pal_pkg::KindW - 1));
      end else if ($urandom_range(0, 7) == 0) begin
        kind = pal_pkg::KIND_CLEAR;
      end else begin
        kind = pal_pkg::KIND_SEARCH;
      end
      send_op(kind, pos, val);
    end
  endtask

  // Receiver back-pressure: switches between patterns at random intervals.
  initial begin
    stall_mode_e mode;
    int unsigned left;
    rsp_if.ready = 1'b0;
    mode = RDY_ALWAYS;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        RDY_ALWAYS:   rsp_if.ready = 1'b1;
        RDY_RANDOM:   rsp_if.ready = ($urandom_range(0, 3) != 0);
        RDY_PERIODIC: rsp_if.ready = ((cycles % 7) < 4);
        default:      rsp_if.ready = ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Compares every result beat with the oldest pending result.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none pending", pal_pkg::ValW'(rsp_if.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", pal_pkg::ValW'(rsp_if.status),
                          pal_pkg::ValW'(want.status));
        if (rsp_if.found_position !== want.found_pos)
          report_mismatch("found_position", pal_pkg::ValW'(rsp_if.found_position),
                          pal_pkg::ValW'(want.found_pos));
        if (rsp_if.read_value !== want.read_val)
          report_mismatch("read_value", rsp_if.read_value, want.read_val);
        if (rsp_if.count !== want.count)
          report_mismatch("count", pal_pkg::ValW'(rsp_if.count),
                          pal_pkg::ValW'(want.count));
      end
    end
  end

  // Reset, then the tests in turn; the sender pauses for all results between them.
  initial begin
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = '0;
    req_if.position = '0;
    req_if.value    = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_for_results();
    test_full_list();
    wait_for_results();
    test_random(RandomItems);
    idle_cycles(1);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("positional_array_list_tb: PASS");
    end else begin
      $display("positional_array_list_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pal_pkg.sv
rtl/pal_if.sv
rtl/pal_ram.sv
rtl/pal_dp.sv
rtl/pal_ctrl.sv
rtl/positional_array_list.sv
tb/positional_array_list_tb.sv
